### rtl/core/imrb_pkg.sv
// ----------------------------------------------------------------------------
// imrb_pkg
// shared types and constants of the interrupt mode register block
// ----------------------------------------------------------------------------
package imrb_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned SRC_W       = 6;
    localparam int unsigned LEN_W       = 7;
    localparam int unsigned INIT_MODE_W = 10;

    localparam logic [DATA_W-1:0] VERSION_WORD = 32'h0202_0102;

    // init mode command word bits
    localparam int unsigned INIT_CLR_BIT  = 7;
    localparam int unsigned INIT_SET_BIT  = 8;
    localparam int unsigned EBUS_CLR_BIT  = 9;
    localparam int unsigned EBUS_SET_BIT  = 10;
    localparam int unsigned DP_CLR_BIT    = 11;
    localparam int unsigned RDRAM_CLR_BIT = 12;
    localparam int unsigned RDRAM_SET_BIT = 13;

    // init mode register bits
    localparam int unsigned INIT_FLAG  = 7;
    localparam int unsigned EBUS_FLAG  = 8;
    localparam int unsigned RDRAM_FLAG = 9;

    // source order SP SI AI VI PI DP from bit 0 up
    localparam int unsigned SRC_DP = 5;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RAISE = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_INIT_MODE = 2'd0,
        REG_VERSION   = 2'd1,
        REG_PENDING   = 2'd2,
        REG_MASK      = 2'd3
    } reg_sel_t;

    typedef struct packed {
        cmd_t              cmd;
        reg_sel_t          reg_index;
        logic [DATA_W-1:0] word;
        logic [SRC_W-1:0]  sources;
    } req_t;

endpackage

### rtl/core/interrupt_mode_register_block.sv
// ----------------------------------------------------------------------------
// interrupt_mode_register_block
// register-bus interrupt controller with init mode, version, pending and mask
// ----------------------------------------------------------------------------
// Each input transfer is one bus access or source event and gives exactly one
// output transfer carrying the read data (zero unless a read) and the
// interrupt line after the access. The block takes one transfer per cycle
// while the output side keeps taking data: a transfer is captured in the
// input register, and once the output register is free or being taken, the
// register update and result are formed and land in the output register.
// Accesses are applied in order, so a read sees every earlier write and
// event.
module interrupt_mode_register_block (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // write_data [31:0], bit_mask [63:32], intr_sources [69:64], zero fill
    input  logic [71:0]                   s_axis_tdata,
    // cmd [1:0], reg_index [3:2]
    input  logic [3:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // read_data [31:0]
    output logic [imrb_pkg::DATA_W-1:0]   m_axis_tdata,
    // irq_line
    output logic                          m_axis_tuser
);

    logic                         in_valid_reg, in_valid_next;
    imrb_pkg::req_t               req_reg, req_next;
    logic                         out_valid_reg, out_valid_next;
    logic [imrb_pkg::DATA_W-1:0]  out_data_reg;
    logic                         out_irq_reg;

    logic                         in_take;
    logic                         advance;
    logic [imrb_pkg::DATA_W-1:0]  rd_data;
    logic                         irq;

    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign in_take       = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        req_next.cmd       = imrb_pkg::cmd_t'(s_axis_tuser[1:0]);
        req_next.reg_index = imrb_pkg::reg_sel_t'(s_axis_tuser[3:2]);
        // bit-level write enable applied on capture
        req_next.word      = s_axis_tdata[31:0] & s_axis_tdata[63:32];
        req_next.sources   = s_axis_tdata[69:64];
    end

    assign in_valid_next  = in_take | (in_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & ~m_axis_tready);

    imrb_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .req     (req_reg),
        .rd_data (rd_data),
        .irq     (irq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            req_reg <= req_next;
        if (advance)
        begin
            out_data_reg <= rd_data;
            out_irq_reg  <= irq;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_irq_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result overwritten");

    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("captured transfer dropped");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && req_reg.cmd != imrb_pkg::CMD_READ |=> out_data_reg == '0)
        else $error("nonzero data on a non-read transfer");

endmodule

### rtl/core/imrb_regfile.sv
// ----------------------------------------------------------------------------
// imrb_regfile
// init mode, pending and mask registers with set/clear bit-pair updates
// ----------------------------------------------------------------------------
module imrb_regfile (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  imrb_pkg::req_t                     req,
    output logic [imrb_pkg::DATA_W-1:0]        rd_data,
    output logic                               irq
);

    logic [imrb_pkg::INIT_MODE_W-1:0] init_mode_reg, init_mode_next;
    logic [imrb_pkg::SRC_W-1:0]       pending_reg, pending_next;
    logic [imrb_pkg::SRC_W-1:0]       mask_reg, mask_next;

    logic [imrb_pkg::DATA_W-1:0]      w;
    logic [imrb_pkg::INIT_MODE_W-1:0] mode_wr;
    logic [imrb_pkg::SRC_W-1:0]       mask_wr;

    assign w = req.word;

    // init mode write: length loads, flags through clear/set pairs, set wins
    always_comb
    begin
        mode_wr = init_mode_reg;
        mode_wr[imrb_pkg::LEN_W-1:0] = w[imrb_pkg::LEN_W-1:0];
        if (w[imrb_pkg::INIT_CLR_BIT])
            mode_wr[imrb_pkg::INIT_FLAG] = 1'b0;
        if (w[imrb_pkg::INIT_SET_BIT])
            mode_wr[imrb_pkg::INIT_FLAG] = 1'b1;
        if (w[imrb_pkg::EBUS_CLR_BIT])
            mode_wr[imrb_pkg::EBUS_FLAG] = 1'b0;
        if (w[imrb_pkg::EBUS_SET_BIT])
            mode_wr[imrb_pkg::EBUS_FLAG] = 1'b1;
        if (w[imrb_pkg::RDRAM_CLR_BIT])
            mode_wr[imrb_pkg::RDRAM_FLAG] = 1'b0;
        if (w[imrb_pkg::RDRAM_SET_BIT])
            mode_wr[imrb_pkg::RDRAM_FLAG] = 1'b1;
    end

    // mask write: even bit clears, odd bit sets
    always_comb
    begin
        for (int i = 0; i < imrb_pkg::SRC_W; i++)
        begin
            mask_wr[i] = (mask_reg[i] & ~w[2*i]) | w[2*i+1];
        end
    end

    always_comb
    begin
        init_mode_next = init_mode_reg;
        pending_next   = pending_reg;
        mask_next      = mask_reg;
        rd_data        = '0;
        unique case (req.cmd)
            imrb_pkg::CMD_READ:
            begin
                unique case (req.reg_index)
                    imrb_pkg::REG_INIT_MODE:
                        rd_data = imrb_pkg::DATA_W'(init_mode_reg);
                    imrb_pkg::REG_VERSION:
                        rd_data = imrb_pkg::VERSION_WORD;
                    imrb_pkg::REG_PENDING:
                        rd_data = imrb_pkg::DATA_W'(pending_reg);
                    imrb_pkg::REG_MASK:
                        rd_data = imrb_pkg::DATA_W'(mask_reg);
                    default:
                        rd_data = '0;
                endcase
            end
            imrb_pkg::CMD_WRITE:
            begin
                if (req.reg_index == imrb_pkg::REG_INIT_MODE)
                begin
                    init_mode_next = mode_wr;
                    if (w[imrb_pkg::DP_CLR_BIT])
                        pending_next[imrb_pkg::SRC_DP] = 1'b0;
                end
                else if (req.reg_index == imrb_pkg::REG_MASK)
                begin
                    mask_next = mask_wr;
                end
            end
            imrb_pkg::CMD_RAISE:
                pending_next = pending_reg | req.sources;
            imrb_pkg::CMD_CLEAR:
                pending_next = pending_reg & ~req.sources;
            default:
                pending_next = pending_reg;
        endcase
    end

    assign irq = |(pending_next & mask_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_mode_reg <= '0;
            pending_reg   <= '0;
            mask_reg      <= '0;
        end
        else if (en)
        begin
            init_mode_reg <= init_mode_next;
            pending_reg   <= pending_next;
            mask_reg      <= mask_next;
        end
    end

    a_raise_sets: assert property (@(posedge clk) disable iff (!rst_n)
        en && req.cmd == imrb_pkg::CMD_RAISE
        |=> (pending_reg & $past(req.sources)) == $past(req.sources))
        else $error("raised sources not pending");

    a_clear_clears: assert property (@(posedge clk) disable iff (!rst_n)
        en && req.cmd == imrb_pkg::CMD_CLEAR
        |=> (pending_reg & $past(req.sources)) == '0)
        else $error("cleared sources still pending");

    a_mask_only_by_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(en && req.cmd == imrb_pkg::CMD_WRITE && req.reg_index == imrb_pkg::REG_MASK)
        |=> $stable(mask_reg))
        else $error("mask changed without a mask write");

    a_mode_only_by_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(en && req.cmd == imrb_pkg::CMD_WRITE
          && req.reg_index == imrb_pkg::REG_INIT_MODE)
        |=> $stable(init_mode_reg))
        else $error("init mode changed without an init mode write");

endmodule
